FILE: rtl/ukcp_pkg.sv
// Package for the UART keyword command parser.
// Holds character codes, register indexes, keyword reset values and shared types.
// No dependencies.
`default_nettype none

package ukcp_pkg;

    localparam int KEY_REGS   = 4;
    localparam int CFG_IDX_W  = 8;

    typedef logic [63:0] t_keyword;

    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    localparam logic [CFG_IDX_W-1:0] CFG_KEYWORD_ZERO  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYWORD_ONE   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYWORD_TWO   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYWORD_THREE = 8'd3;

    localparam t_keyword KEYWORD_ZERO_RST  = 64'h0000_006e_6f64_656c;
    localparam t_keyword KEYWORD_ONE_RST   = 64'h0000_6666_6f64_656c;
    localparam t_keyword KEYWORD_TWO_RST   = 64'h0000_0000_0064_636c;
    localparam t_keyword KEYWORD_THREE_RST = 64'h0000_006f_7672_6573;

    typedef struct packed {
        logic       emit;
        logic [1:0] command_index;
        logic [7:0] command_value;
    } t_cmd_result;

endpackage

`default_nettype wire

FILE: rtl/ukcp_if.sv
// Channel interfaces for the UART keyword command parser.
// Received bytes, command results and configuration writes; uses ukcp_pkg.
`default_nettype none

interface ukcp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface ukcp_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] command_index;
    logic [7:0] command_value;
    modport source (output valid, output command_index, output command_value, input ready);
    modport sink (input valid, input command_index, input command_value, output ready);
endinterface

interface ukcp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ukcp_pkg::CFG_IDX_W-1:0] index;
    ukcp_pkg::t_keyword             data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/uart_keyword_command_parser.sv
// An LF byte is held in the input register; its result is loaded into the output register when the parser steps on it.
// Throughput: one received byte per cycle while the result side keeps up.
// An input register feeds the parser state update; an output register holds each result.
// Reset (synchronous, active low) clears the line state and restores the four keyword
// registers to their default keywords. Top level; uses ukcp_pkg, ukcp_if and ukcp_parser.
`default_nettype none

module uart_keyword_command_parser #(
    parameter int WORD_LIMIT    = 18,
    parameter int KEYWORD_COUNT = 4,
    parameter int KEYWORD_CHARS = 8
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ukcp_rx_if.sink    i_rx,
    ukcp_cfg_if.sink   i_cfg,
    ukcp_cmd_if.source o_cmd
);

    ukcp_pkg::t_keyword r_keyword [ukcp_pkg::KEY_REGS];

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    logic [1:0] r_out_index;
    logic [7:0] r_out_value;

    ukcp_pkg::t_cmd_result w_result;
    logic                  w_advance;

    assign w_advance   = r_in_valid && (!w_result.emit || !r_out_valid || o_cmd.ready);
    assign i_rx.ready  = !r_in_valid || w_advance;
    assign i_cfg.ready = 1'b1;

    assign o_cmd.valid         = r_out_valid;
    assign o_cmd.command_index = r_out_index;
    assign o_cmd.command_value = r_out_value;

    ukcp_parser #(
        .WORD_LIMIT    (WORD_LIMIT),
        .KEYWORD_COUNT (KEYWORD_COUNT),
        .KEYWORD_CHARS (KEYWORD_CHARS)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_advance),
        .i_byte    (r_in_byte),
        .i_keyword (r_keyword),
        .o_result  (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keyword[0] <= ukcp_pkg::KEYWORD_ZERO_RST;
            r_keyword[1] <= ukcp_pkg::KEYWORD_ONE_RST;
            r_keyword[2] <= ukcp_pkg::KEYWORD_TWO_RST;
            r_keyword[3] <= ukcp_pkg::KEYWORD_THREE_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                ukcp_pkg::CFG_KEYWORD_ZERO: begin
                    r_keyword[0] <= i_cfg.data;
                end
                ukcp_pkg::CFG_KEYWORD_ONE: begin
                    r_keyword[1] <= i_cfg.data;
                end
                ukcp_pkg::CFG_KEYWORD_TWO: begin
                    r_keyword[2] <= i_cfg.data;
                end
                ukcp_pkg::CFG_KEYWORD_THREE: begin
                    r_keyword[3] <= i_cfg.data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_result.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_cmd.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_result.emit) begin
            r_out_index <= w_result.command_index;
            r_out_value <= w_result.command_value;
        end
    end

`ifndef SYNTHESIS
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_result.emit) |=> r_out_valid)
        else $error("emitted result was not loaded into the output register");

    a_input_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rx.valid && i_rx.ready) |=> r_in_valid)
        else $error("accepted byte was not captured");
`endif

endmodule

`default_nettype wire

FILE: rtl/ukcp_parser.sv
// Line parser state: held byte, keyword match flags, word position and value sum.
// Computes the result for the presented byte and updates state on each step; uses ukcp_pkg.
`default_nettype none

module ukcp_parser #(
    parameter int WORD_LIMIT    = 18,
    parameter int KEYWORD_COUNT = 4,
    parameter int KEYWORD_CHARS = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_step,
    input  wire logic [7:0]            i_byte,
    input  wire ukcp_pkg::t_keyword    i_keyword [ukcp_pkg::KEY_REGS],
    output ukcp_pkg::t_cmd_result      o_result
);

    logic [7:0]               r_held_char;
    logic                     r_held_valid;
    logic                     r_after_space;
    logic [4:0]               r_word_pos;
    logic [KEYWORD_COUNT-1:0] r_match_flags;
    logic                     r_too_long;
    logic [7:0]               r_value_sum;

    logic [7:0]               n_held_char;
    logic                     n_held_valid;
    logic                     n_after_space;
    logic [4:0]               n_word_pos;
    logic [KEYWORD_COUNT-1:0] n_match_flags;
    logic                     n_too_long;
    logic [7:0]               n_value_sum;

    logic [7:0] w_key_byte [KEYWORD_COUNT];
    logic [1:0] w_first_match;

    for (genvar g = 0; g < KEYWORD_COUNT; g++) begin : g_key
        if (g < ukcp_pkg::KEY_REGS) begin : g_reg
            assign w_key_byte[g] = i_keyword[g][{r_word_pos[2:0], 3'b000} +: 8];
        end else begin : g_nul
            assign w_key_byte[g] = 8'h00;
        end
    end

    always_comb begin
        w_first_match = 2'd0;
        for (int k = KEYWORD_COUNT - 1; k >= 0; k--) begin
            if (r_match_flags[k]) begin
                w_first_match = 2'(k);
            end
        end
    end

    always_comb begin
        n_held_char   = r_held_char;
        n_held_valid  = r_held_valid;
        n_after_space = r_after_space;
        n_word_pos    = r_word_pos;
        n_match_flags = r_match_flags;
        n_too_long    = r_too_long;
        n_value_sum   = r_value_sum;

        o_result.emit          = 1'b0;
        o_result.command_index = w_first_match;
        o_result.command_value = r_value_sum;

        if (i_byte == ukcp_pkg::CHAR_LF) begin
            o_result.emit = r_after_space && !r_too_long && (|r_match_flags);
            n_held_char   = 8'h00;
            n_held_valid  = 1'b0;
            n_after_space = 1'b0;
            n_word_pos    = 5'd0;
            n_match_flags = '1;
            n_too_long    = 1'b0;
            n_value_sum   = 8'h00;
        end else begin
            if (r_held_valid) begin
                if (r_after_space) begin
                    n_value_sum = {r_value_sum[4:0], 3'b000} + {r_value_sum[6:0], 1'b0}
                                  + r_held_char - ukcp_pkg::CHAR_ZERO;
                end else if (!r_too_long) begin
                    if (r_held_char == ukcp_pkg::CHAR_SPACE) begin
                        n_after_space = 1'b1;
                        if (r_word_pos < 5'(KEYWORD_CHARS)) begin
                            for (int k = 0; k < KEYWORD_COUNT; k++) begin
                                if (w_key_byte[k] != 8'h00) begin
                                    n_match_flags[k] = 1'b0;
                                end
                            end
                        end
                    end else if (r_word_pos >= 5'(WORD_LIMIT)) begin
                        n_too_long = 1'b1;
                    end else begin
                        for (int k = 0; k < KEYWORD_COUNT; k++) begin
                            if (r_word_pos >= 5'(KEYWORD_CHARS)
                                || w_key_byte[k] != r_held_char) begin
                                n_match_flags[k] = 1'b0;
                            end
                        end
                        n_word_pos = r_word_pos + 5'd1;
                    end
                end
            end
            n_held_char  = i_byte;
            n_held_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_char   <= 8'h00;
            r_held_valid  <= 1'b0;
            r_after_space <= 1'b0;
            r_word_pos    <= 5'd0;
            r_match_flags <= '1;
            r_too_long    <= 1'b0;
            r_value_sum   <= 8'h00;
        end else if (i_step) begin
            r_held_char   <= n_held_char;
            r_held_valid  <= n_held_valid;
            r_after_space <= n_after_space;
            r_word_pos    <= n_word_pos;
            r_match_flags <= n_match_flags;
            r_too_long    <= n_too_long;
            r_value_sum   <= n_value_sum;
        end
    end

`ifndef SYNTHESIS
    a_pos_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_word_pos <= 5'(WORD_LIMIT))
        else $error("word position exceeds the word limit");

    a_byte_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_byte != ukcp_pkg::CHAR_LF) |=> r_held_valid)
        else $error("non-LF byte was not held");

    a_line_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_byte == ukcp_pkg::CHAR_LF) |=>
            (&r_match_flags) && !r_after_space && !r_held_valid && !r_too_long)
        else $error("line state not cleared after LF");
`endif

endmodule

`default_nettype wire
